/* hdl/pcsc_pkg.sv */
// Package for the pixel color space converter: mode codes, payload types and
// the reciprocal constants used for division by fixed divisors. No dependencies.
package pcsc_pkg;
    typedef enum logic [1:0] {
        MODE_GRAY    = 2'd0,
        MODE_RGB2HSV = 2'd1,
        MODE_INVERT  = 2'd2,
        MODE_HSV2RGB = 2'd3
    } mode_t;

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       last;
    } pix_t;

    // Division by 255 is a multiply by this value followed by a shift of 24.
    localparam logic [16:0] DIV255_MUL   = 17'd65794;
    // Division by 15300 is a multiply by this value followed by a shift of 36.
    localparam logic [22:0] DIV15300_MUL = 23'd4491470;
    // Division by 3 is a multiply by this value followed by a shift of 11.
    localparam logic [9:0]  DIV3_MUL     = 10'd683;
endpackage

/* hdl/pcsc_if.sv */
// Valid/ready stream interface carrying one pixel per transfer.
// Depends on pcsc_pkg.
interface pcsc_if;
    logic               valid;
    logic               ready;
    pcsc_pkg::pix_t     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/pixel_color_space_convert_unit.sv */
// Pixel color space converter, top level.
// Four register stages; throughput one pixel per cycle while the output is not
// stalled. A stall holds every stage in place.
// Reset clears the mode to gray and all stage valid bits.
// Depends on pcsc_pkg, pcsc_if and pcsc_div.
module pixel_color_space_convert_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_data,
    pcsc_if.sink       s_in,
    pcsc_if.source     m_out
);
    import pcsc_pkg::*;

    mode_t mode_reg;
    logic [3:0] vld_reg;
    logic adv;
    assign adv = !vld_reg[3] || m_out.ready;
    assign s_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_GRAY;
        else if (cfg_we)
            mode_reg <= mode_t'(cfg_data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[2:0], s_in.valid};
    end

    // Stage 1: capture, max/min/numerators.
    logic [7:0] c0_reg, c1_reg, c2_reg, mx_reg, d_reg;
    logic sel_reg;
    logic [2:0] last_reg;
    logic [15:0] hn_reg, sn_reg;
    logic [7:0] pn_reg;
    logic [13:0] qn_reg, tn_reg;
    logic [2:0] sec_reg;
    logic [7:0] mx_n, mn_n, d_n, r, g, b;
    logic [15:0] hn_n, sn_n;
    logic [8:0] hh;
    logic [2:0] sec_n;
    logic [5:0] f, fc_n;
    assign r = s_in.data.c0;
    assign g = s_in.data.c1;
    assign b = s_in.data.c2;
    always_comb
    begin
        mx_n = (r >= g) ? r : g;
        if (b > mx_n) mx_n = b;
        mn_n = (r <= g) ? r : g;
        if (b < mn_n) mn_n = b;
        d_n = mx_n - mn_n;
        if (mx_n == r)
            hn_n = 16'(180 * d_n + 30 * g - 30 * b);
        else if (mx_n == g)
            hn_n = 16'(60 * d_n + 30 * b - 30 * r);
        else
            hn_n = 16'(120 * d_n + 30 * r - 30 * g);
        hh = {b, 1'b0};
        if (hh >= 9'd360) hh = '0;
        if (hh >= 9'd300)
        begin
            sec_n = 3'd5;
            f = 6'(hh - 9'd300);
        end
        else if (hh >= 9'd240)
        begin
            sec_n = 3'd4;
            f = 6'(hh - 9'd240);
        end
        else if (hh >= 9'd180)
        begin
            sec_n = 3'd3;
            f = 6'(hh - 9'd180);
        end
        else if (hh >= 9'd120)
        begin
            sec_n = 3'd2;
            f = 6'(hh - 9'd120);
        end
        else if (hh >= 9'd60)
        begin
            sec_n = 3'd1;
            f = 6'(hh - 9'd60);
        end
        else
        begin
            sec_n = 3'd0;
            f = 6'(hh);
        end
    end

    logic [13:0] sf_n, sg_n;
    assign fc_n = 6'd60 - f;
    assign sf_n = {6'd0, g} * {8'd0, f};
    assign sg_n = {6'd0, g} * {8'd0, fc_n};
    assign sn_n = {8'd0, d_n} * 16'd255;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_reg <= r;
            c1_reg <= g;
            c2_reg <= b;
            mx_reg <= mx_n;
            d_reg <= d_n;
            hn_reg <= hn_n;
            sn_reg <= sn_n;
            sec_reg <= sec_n;
            sel_reg <= (mx_n == r);
            pn_reg <= 8'd255 - g;
            qn_reg <= 14'd15300 - sf_n;
            tn_reg <= 14'd15300 - sg_n;
            last_reg[0] <= s_in.data.last;
            last_reg[2:1] <= last_reg[1:0];
        end
    end

    // Stage 2: multiplications by V, upper quotient bits of hue and saturation.
    logic [7:0] c0b, c1b, c2b, mxb, db;
    logic selb;
    logic [2:0] secb;
    logic [15:0] pm_reg;
    logic [21:0] qm_reg, tm_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0b <= c0_reg; c1b <= c1_reg; c2b <= c2_reg;
            mxb <= mx_reg; db <= d_reg;
            selb <= sel_reg; secb <= sec_reg;
            pm_reg <= {8'd0, c0_reg} * {8'd0, pn_reg};
            qm_reg <= {14'd0, c0_reg} * {8'd0, qn_reg};
            tm_reg <= {14'd0, c0_reg} * {8'd0, tn_reg};
        end
    end

    logic [7:0] hq, sq;
    pcsc_div #(.NW(16), .DW(8), .QW(8)) u_hdiv (
        .clk (clk),
        .en  (adv),
        .num (hn_reg),
        .den (d_reg),
        .quo (hq)
    );
    pcsc_div #(.NW(16), .DW(8), .QW(8)) u_sdiv (
        .clk (clk),
        .en  (adv),
        .num (sn_reg),
        .den (mx_reg),
        .quo (sq)
    );

    // Stage 3: lower quotient bits, divisions by 255 and 15300.
    logic [32:0] pr;
    logic [44:0] qr, tr;
    assign pr = {17'd0, pm_reg} * {16'd0, DIV255_MUL};
    assign qr = {23'd0, qm_reg} * {22'd0, DIV15300_MUL};
    assign tr = {23'd0, tm_reg} * {22'd0, DIV15300_MUL};

    logic [7:0] c0c, c1c, c2c, mxc, hc, sc, pc, qc, tc;
    logic [2:0] secc;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0c <= c0b; c1c <= c1b; c2c <= c2b; mxc <= mxb; secc <= secb;
            if (db == 8'd0)
                hc <= '0;
            else if (selb && hq >= 8'd180)
                hc <= hq - 8'd180;
            else
                hc <= hq;
            sc <= (mxb == 8'd0) ? 8'd0 : sq;
            pc <= pr[31:24]; qc <= qr[43:36]; tc <= tr[43:36];
        end
    end

    // Stage 4: mode select into output register.
    pix_t o_n, o_reg;
    logic [9:0] sum;
    logic [19:0] gp;
    assign sum = 10'(c0c) + 10'(c1c) + 10'(c2c);
    assign gp = {10'd0, sum} * {10'd0, DIV3_MUL};
    always_comb
    begin
        o_n.last = last_reg[2];
        o_n.c0 = '0; o_n.c1 = '0; o_n.c2 = '0;
        case (mode_reg)
            MODE_GRAY:    o_n.c0 = gp[18:11];
            MODE_RGB2HSV: begin o_n.c0 = mxc; o_n.c1 = sc; o_n.c2 = hc; end
            MODE_INVERT:  begin o_n.c0 = ~c0c; o_n.c1 = ~c1c; o_n.c2 = ~c2c; end
            default:
            begin
                case (secc)
                    3'd0: begin o_n.c0 = c0c; o_n.c1 = tc; o_n.c2 = pc; end
                    3'd1: begin o_n.c0 = qc; o_n.c1 = c0c; o_n.c2 = pc; end
                    3'd2: begin o_n.c0 = pc; o_n.c1 = c0c; o_n.c2 = tc; end
                    3'd3: begin o_n.c0 = pc; o_n.c1 = qc; o_n.c2 = c0c; end
                    3'd4: begin o_n.c0 = tc; o_n.c1 = pc; o_n.c2 = c0c; end
                    default: begin o_n.c0 = c0c; o_n.c1 = pc; o_n.c2 = qc; end
                endcase
            end
        endcase
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            o_reg <= o_n;
    end
    assign m_out.valid = vld_reg[3];
    assign m_out.data = o_reg;
endmodule

/* hdl/pcsc_div.sv */
// Restoring divider: the upper half of the quotient bits is formed
// before an internal register, the lower half after it. Requires num < den << QW.
// No dependencies; used by the converter datapath.
module pcsc_div #(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int QW = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);
    localparam int HB = QW / 2;

    logic [NW-1:0] rem_a, rem_b, rem_reg;
    logic [QW-1:0] q_a, q_b, q_reg;
    logic [DW-1:0] den_reg;
    logic [NW-1:0] den_w, den_rw;

    assign den_w  = {{(NW-DW){1'b0}}, den};
    assign den_rw = {{(NW-DW){1'b0}}, den_reg};

    always_comb
    begin
        rem_a = num;
        q_a = '0;
        for (int i = QW - 1; i >= HB; i--)
        begin
            if (rem_a >= (den_w << i))
            begin
                rem_a = rem_a - (den_w << i);
                q_a[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_a;
            q_reg <= q_a;
            den_reg <= den;
        end
    end

    always_comb
    begin
        rem_b = rem_reg;
        q_b = q_reg;
        for (int i = HB - 1; i >= 0; i--)
        begin
            if (rem_b >= (den_rw << i))
            begin
                rem_b = rem_b - (den_rw << i);
                q_b[i] = 1'b1;
            end
        end
    end

    assign quo = q_b;
endmodule
